// ----- hdl/greedy_element_coloring_defines.svh -----
`ifndef GREEDY_ELEMENT_COLORING_DEFINES_SVH
`define GREEDY_ELEMENT_COLORING_DEFINES_SVH

// same-cycle implication on i_clk, off while i_rst_n is low
`define GEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gec assertion failed");

// next-cycle implication on i_clk, off while i_rst_n is low
`define GEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gec assertion failed");

`endif

// ----- hdl/gec_pkg.sv -----
package gec_pkg;

    localparam int NODE_W      = 12;
    localparam int COUNT_W     = 4;
    localparam int NODE_FIELDS = 8;
    localparam int SEL_W       = 3;
    localparam int INDEX_W     = 16;
    localparam int COLOR_W     = 4;

    typedef struct packed {
        logic [COUNT_W-1:0] node_count;
        logic [NODE_W-1:0]  node_0;
        logic [NODE_W-1:0]  node_1;
        logic [NODE_W-1:0]  node_2;
        logic [NODE_W-1:0]  node_3;
        logic [NODE_W-1:0]  node_4;
        logic [NODE_W-1:0]  node_5;
        logic [NODE_W-1:0]  node_6;
        logic [NODE_W-1:0]  node_7;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] elem_seq;
        logic [COLOR_W-1:0] color;
        logic               no_color;
    } t_out_item;

    typedef struct packed {
        logic item_take;
        logic res_valid;
        logic clearing;
    } t_eng_stat;

endpackage

// ----- hdl/gec_mask_mem.sv -----
module gec_mask_mem #(
    parameter int DEPTH = 4096,
    parameter int DW    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/gec_engine.sv -----
`include "greedy_element_coloring_defines.svh"

module gec_engine #(
    parameter int MAX_NODES      = 4096,
    parameter int MAX_COLORS     = 16,
    parameter int NODES_PER_ELEM = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_valid,
    input  gec_pkg::t_in_item            i_item,
    input  logic                         i_res_ready,
    output gec_pkg::t_out_item           o_res,
    output gec_pkg::t_eng_stat           o_stat,
    output logic                         o_we,
    output logic [$clog2(MAX_NODES)-1:0] o_waddr,
    output logic [MAX_COLORS-1:0]        o_wdata,
    output logic [$clog2(MAX_NODES)-1:0] o_raddr,
    input  logic [MAX_COLORS-1:0]        i_rdata
);

    localparam int AW   = $clog2(MAX_NODES);
    localparam int CNTW = $clog2(NODES_PER_ELEM + 1);
    localparam int IW   = (NODES_PER_ELEM > 1) ? $clog2(NODES_PER_ELEM) : 1;
    localparam int CW   = $clog2(MAX_COLORS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CALC,
        S_WRITE,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [AW-1:0]                   r_clr;
    logic [CNTW-1:0]                 r_k;
    logic [CNTW-1:0]                 r_nslots;
    logic                            r_rd_pend;
    logic [IW-1:0]                   r_rd_slot;
    logic                            r_rd_ok;
    logic [gec_pkg::INDEX_W-1:0]     r_elem;
    gec_pkg::t_in_item               r_cur;
    logic [MAX_COLORS-1:0]           r_used;
    logic [MAX_COLORS-1:0]           r_masks [NODES_PER_ELEM];
    logic [CW-1:0]                   r_color;
    logic                            r_none;

    logic [gec_pkg::NODE_W-1:0]      w_nodes [gec_pkg::NODE_FIELDS];
    logic [gec_pkg::NODE_W-1:0]      w_cur_node;
    logic                            w_cur_ok;
    logic                            w_last;
    logic [CNTW-1:0]                 w_in_slots;
    logic                            w_take;
    logic [MAX_COLORS-1:0]           w_rd_mask;
    logic [MAX_COLORS-1:0]           w_used_all;
    logic [MAX_COLORS-1:0]           w_free;
    logic [CW-1:0]                   w_color;
    logic                            w_none;

    assign w_nodes[0] = r_cur.node_0;
    assign w_nodes[1] = r_cur.node_1;
    assign w_nodes[2] = r_cur.node_2;
    assign w_nodes[3] = r_cur.node_3;
    assign w_nodes[4] = r_cur.node_4;
    assign w_nodes[5] = r_cur.node_5;
    assign w_nodes[6] = r_cur.node_6;
    assign w_nodes[7] = r_cur.node_7;

    assign w_cur_node = w_nodes[gec_pkg::SEL_W'(r_k)];
    assign w_cur_ok   = 32'(w_cur_node) < 32'(MAX_NODES);
    assign w_last     = (r_k == r_nslots - CNTW'(1));
    assign w_in_slots = (32'(i_item.node_count) > 32'(NODES_PER_ELEM))
                        ? CNTW'(NODES_PER_ELEM) : CNTW'(i_item.node_count);

    assign w_take = i_item_valid
                    && ((r_state == S_IDLE) || ((r_state == S_DONE) && i_res_ready));

    assign w_rd_mask  = r_rd_ok ? i_rdata : '0;
    assign w_used_all = r_used | (r_rd_pend ? w_rd_mask : '0);
    assign w_free     = ~w_used_all;
    assign w_none     = ~|w_free;

    always_comb begin
        w_color = '0;
        for (int i = MAX_COLORS - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_color = CW'(i);
            end
        end
    end

    // clear sweep and write-back share the single write port
    always_comb begin
        o_we    = 1'b0;
        o_waddr = AW'(w_cur_node);
        o_wdata = r_masks[IW'(r_k)] | (MAX_COLORS'(1) << r_color);
        case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                o_wdata = '0;
            end
            S_WRITE: begin
                o_we = w_cur_ok;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    assign o_raddr = AW'(w_cur_node);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_rd_pend <= 1'b0;
            r_elem    <= '0;
        end else begin
            r_rd_pend <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MAX_NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_take) begin
                        r_state <= (w_in_slots == '0) ? S_CALC : S_READ;
                    end
                end
                S_READ: begin
                    r_rd_pend <= 1'b1;
                    if (w_last) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= (!w_none && (r_nslots != '0)) ? S_WRITE : S_DONE;
                end
                S_WRITE: begin
                    if (w_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_elem <= r_elem + gec_pkg::INDEX_W'(1);
                        if (w_take) begin
                            r_state <= (w_in_slots == '0) ? S_CALC : S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_masks[r_rd_slot] <= w_rd_mask;
            r_used             <= r_used | w_rd_mask;
        end
        if (w_take) begin
            r_cur    <= i_item;
            r_nslots <= w_in_slots;
            r_k      <= '0;
            r_used   <= '0;
        end
        case (r_state)
            S_READ: begin
                r_rd_slot <= IW'(r_k);
                r_rd_ok   <= w_cur_ok;
                r_k       <= r_k + CNTW'(1);
            end
            S_CALC: begin
                r_color <= w_color;
                r_none  <= w_none;
                r_k     <= '0;
            end
            S_WRITE: begin
                r_k <= r_k + CNTW'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_res.elem_seq   = r_elem;
    assign o_res.color      = r_none ? '0 : gec_pkg::COLOR_W'(r_color);
    assign o_res.no_color   = r_none;

    assign o_stat.item_take = w_take;
    assign o_stat.res_valid = (r_state == S_DONE);
    assign o_stat.clearing  = (r_state == S_CLEAR);

    `GEC_ASSERT_NOW(a_write_has_color, o_we && !o_stat.clearing, (r_state == S_WRITE) && !r_none)
    `GEC_ASSERT_NOW(a_quiet_while_clearing, r_state == S_CLEAR, !o_stat.res_valid && !w_take)
    `GEC_ASSERT_NEXT(a_take_starts_work, w_take, (r_state == S_READ) || (r_state == S_CALC))

endmodule

// ----- hdl/greedy_element_coloring.sv -----
// Each accepted request is held in an input register until the engine takes it; the engine
// handles one element at a time: the single mask memory takes the N reads, N = min(node_count, 8),
// one color pick, then the N write-backs of each element (none when no color is free).
// Reset: synchronous, active low; afterwards the masks are cleared one entry per cycle,
// all MAX_NODES entries, with the input stalled. Element index restarts at zero.
module greedy_element_coloring #(
    parameter int MAX_NODES      = 4096,
    parameter int MAX_COLORS     = 16,
    parameter int NODES_PER_ELEM = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gec_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gec_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(MAX_NODES);

    gec_pkg::t_in_item     r_hold;
    logic                  r_hold_valid;
    gec_pkg::t_out_item    r_out;
    logic                  r_out_valid;

    gec_pkg::t_out_item    w_res;
    gec_pkg::t_eng_stat    w_stat;
    logic                  w_out_free;
    logic                  w_in_acc;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [MAX_COLORS-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [MAX_COLORS-1:0] w_rdata;

    assign o_in_stall = w_stat.clearing || (r_hold_valid && !w_stat.item_take);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_hold_valid <= 1'b1;
            end else if (w_stat.item_take) begin
                r_hold_valid <= 1'b0;
            end
            if (w_stat.res_valid && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_hold <= i_in_item;
        end
        if (w_stat.res_valid && w_out_free) begin
            r_out <= w_res;
        end
    end

    gec_engine #(
        .MAX_NODES      (MAX_NODES),
        .MAX_COLORS     (MAX_COLORS),
        .NODES_PER_ELEM (NODES_PER_ELEM)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_hold_valid),
        .i_item       (r_hold),
        .i_res_ready  (w_out_free),
        .o_res        (w_res),
        .o_stat       (w_stat),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_raddr      (w_raddr),
        .i_rdata      (w_rdata)
    );

    gec_mask_mem #(
        .DEPTH (MAX_NODES),
        .DW    (MAX_COLORS)
    ) u_mask_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- test/greedy_element_coloring_tb.sv -----
`timescale 1ns / 1ps

module greedy_element_coloring_tb;

    localparam int MAX_NODES      = 4096;
    localparam int MAX_COLORS     = 16;
    localparam int NODES_PER_ELEM = 8;
    localparam int RANDOM_ELEMS   = 1800;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int NODE_W         = gec_pkg::NODE_W;
    localparam int NODE_FIELDS    = gec_pkg::NODE_FIELDS;
    localparam int COUNT_W        = gec_pkg::COUNT_W;
    localparam int COLOR_W        = gec_pkg::COLOR_W;
    localparam int INDEX_W        = gec_pkg::INDEX_W;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    gec_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    gec_pkg::t_out_item o_out_item;

    gec_pkg::t_in_item     elem_queue[$];
    gec_pkg::t_out_item    color_expect[$];
    logic [MAX_COLORS-1:0] node_masks[MAX_NODES];
    logic [INDEX_W-1:0]    elem_count;
    logic                  elem_taken = 1'b0;
    int                    in_gap_left = 0;
    int                    out_stall_left = 0;
    int                    errors = 0;
    int                    cycles = 0;

    greedy_element_coloring #(
        .MAX_NODES(MAX_NODES),
        .MAX_COLORS(MAX_COLORS),
        .NODES_PER_ELEM(NODES_PER_ELEM)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // first count node fields drawn from [lo, hi], the rest anywhere
    function automatic gec_pkg::t_in_item pick_elem(int cnt, int lo, int hi);
        gec_pkg::t_in_item e;
        int                k;
        e = '0;
        e.node_count = cnt[COUNT_W-1:0];
        for (k = 0; k < NODE_FIELDS; k++) begin
            e[(NODE_FIELDS-1-k)*NODE_W +: NODE_W] =
                (k < cnt) ? NODE_W'($urandom_range(hi, lo))
                          : NODE_W'($urandom_range(MAX_NODES-1, 0));
        end
        return e;
    endfunction

    function automatic void add_elem(gec_pkg::t_in_item e);
        elem_queue.insert(elem_queue.size(), e);
    endfunction

    // lowest color free on all nodes of the element, then mark it on each node
    function automatic gec_pkg::t_out_item assign_color(gec_pkg::t_in_item e);
        logic [NODE_W-1:0]     node;
        logic [MAX_COLORS-1:0] taken;
        gec_pkg::t_out_item    r;
        int                    n;
        int                    k;
        int                    c;
        n = (e.node_count > NODES_PER_ELEM) ? NODES_PER_ELEM : int'(e.node_count);
        taken = '0;
        for (k = 0; k < n; k++) begin
            node = e[(NODE_FIELDS-1-k)*NODE_W +: NODE_W];
            taken |= node_masks[node];
        end
        r.elem_seq = elem_count;
        r.color = '0;
        r.no_color = 1'b1;
        for (c = MAX_COLORS - 1; c >= 0; c--) begin
            if (!taken[c]) begin
                r.color = c[COLOR_W-1:0];
                r.no_color = 1'b0;
            end
        end
        if (!r.no_color) begin
            for (k = 0; k < n; k++) begin
                node = e[(NODE_FIELDS-1-k)*NODE_W +: NODE_W];
                node_masks[node][r.color] = 1'b1;
            end
        end
        elem_count = elem_count + 1'b1;
        return r;
    endfunction

    // quiet stretches every 256 requests, and none near the end
    function automatic logic idle_allowed();
        return elem_queue.size() > 200 && (elem_queue.size() % 256) >= 64;
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !elem_taken) begin
                // stalled request holds
            end else if (in_gap_left > 0) begin
                in_gap_left <= in_gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (elem_queue.size() > 0 && idle_allowed()
                         && $urandom_range(9, 0) == 0) begin
                in_gap_left <= $urandom_range(12, 0);
                i_in_valid <= 1'b0;
            end else if (elem_queue.size() > 0) begin
                i_in_item <= elem_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_stall_left > 0) begin
            out_stall_left <= out_stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_allowed() && $urandom_range(7, 0) == 0) begin
            out_stall_left <= $urandom_range(12, 0);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        gec_pkg::t_out_item want;
        if (i_rst_n) begin
            elem_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                color_expect.insert(color_expect.size(), assign_color(i_in_item));
            end
            if (o_out_valid && !i_out_stall) begin
                if (color_expect.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %p",
                             $time, o_out_item);
                end else begin
                    want = color_expect.pop_front();
                    if (o_out_item.elem_seq !== want.elem_seq) begin
                        errors++;
                        $display("%0t: elem_seq expected %0d got %0d",
                                 $time, want.elem_seq, o_out_item.elem_seq);
                    end
                    if (o_out_item.color !== want.color) begin
                        errors++;
                        $display("%0t: color of element %0d expected %0d got %0d",
                                 $time, want.elem_seq, want.color, o_out_item.color);
                    end
                    if (o_out_item.no_color !== want.no_color) begin
                        errors++;
                        $display("%0t: no_color of element %0d expected %0b got %0b",
                                 $time, want.elem_seq, want.no_color,
                                 o_out_item.no_color);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("greedy_element_coloring_tb NOT OK");
            $finish;
        end
    end

    initial begin
        gec_pkg::t_in_item e;
        int                i;
        int                k;
        int                sel;
        int                lo;
        int                span;
        for (i = 0; i < MAX_NODES; i++) begin
            node_masks[i] = '0;
        end
        elem_count = '0;

        // no nodes, single node twice, saturated count with repeats
        add_elem(pick_elem(0, 0, MAX_NODES - 1));
        add_elem(pick_elem(1, 0, 0));
        add_elem(pick_elem(1, 0, 0));
        e = pick_elem(15, MAX_NODES - 1, MAX_NODES - 1);
        e.node_0 = '0;
        add_elem(e);
        e = pick_elem(9, 4000, MAX_NODES - 1);
        e.node_0 = 12'hAAA;
        e.node_1 = 12'h555;
        add_elem(e);
        // hub node shared by fresh partners uses up every color
        for (k = 0; k < MAX_COLORS; k++) begin
            e = pick_elem(2, 3000 + k, 3000 + k);
            e.node_1 = 12'd2048;
            add_elem(e);
        end
        e = pick_elem(2, 3100, 3100);
        e.node_1 = 12'd2048;
        add_elem(e);
        add_elem(pick_elem(1, 2048, 2048));
        add_elem(pick_elem(8, 2048, 2048));

        lo = 0;
        span = 8;
        for (i = 0; i < RANDOM_ELEMS; i++) begin
            if (i % 150 == 0) begin
                span = $urandom_range(40, 6);
                lo = $urandom_range(MAX_NODES - 1 - span, 0);
            end
            sel = $urandom_range(99, 0);
            if (sel < 65) begin
                e = pick_elem($urandom_range(NODES_PER_ELEM, 1), lo, lo + span);
            end else if (sel < 85) begin
                e = pick_elem($urandom_range(NODES_PER_ELEM, 1), 0, MAX_NODES - 1);
            end else if (sel < 95) begin
                e = pick_elem($urandom_range(15, NODES_PER_ELEM + 1), lo, lo + span);
            end else begin
                e = pick_elem(0, 0, MAX_NODES - 1);
            end
            add_elem(e);
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (elem_queue.size() > 0 || i_in_valid) @(posedge i_clk);
        while (color_expect.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0 && color_expect.size() == 0) begin
            $display("greedy_element_coloring_tb OK");
        end else begin
            $display("greedy_element_coloring_tb NOT OK");
        end
        $finish;
    end

endmodule
